@@ rtl/sha256_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned TOTAL_W     = 61;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef enum logic [2:0] {
        WSRC_MSG  = 3'b001,
        WSRC_PAD  = 3'b010,
        WSRC_ZERO = 3'b100
    } wsrc_t;

    typedef struct packed {
        logic        buf_wr;
        wsrc_t       buf_src;
        logic        len_wr;
        logic        total_clr;
        logic        total_inc;
        logic        round_init;
        logic        round_step;
        logic        hash_update;
        logic        hash_init;
        logic [2:0]  out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0]  round_idx;
    } dp_status_t;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[i];
    endfunction

    function automatic logic [31:0] start_h(input logic [2:0] i);
        logic [31:0] h [8];
        h = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
        };
        return h[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

`default_nettype wire

@@ rtl/sha256_datapath.sv @@
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Byte window that collects a block and then serves as the message schedule,
// beside the round registers and hash words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_datapath (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire sha256_pkg::dp_cmd_t    cmd,
    input  wire logic [7:0]             msg_byte,
    output sha256_pkg::dp_status_t      status,
    output logic [31:0]                 hash_word
);

    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  round_reg;
    logic [sha256_pkg::TOTAL_W-1:0] total_reg;
    logic [63:0] bits;
    logic [7:0]  wr_byte;
    logic [31:0] w_cur;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] s0;
    logic [31:0] s1;

    assign bits = {total_reg, 3'b000};

    always_comb begin
        case (cmd.buf_src)
            sha256_pkg::WSRC_MSG:  wr_byte = msg_byte;
            sha256_pkg::WSRC_PAD:  wr_byte = sha256_pkg::PAD_BYTE;
            default:               wr_byte = 8'h00;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.total_clr) begin
            total_reg <= '0;
        end else if (cmd.total_inc) begin
            total_reg <= total_reg + 1'b1;
        end
    end

    assign w_cur = w_reg[0];

    always_comb begin
        s0 = sha256_pkg::rotr(w_reg[1], 7) ^ sha256_pkg::rotr(w_reg[1], 18)
             ^ (w_reg[1] >> 3);
        s1 = sha256_pkg::rotr(w_reg[14], 17) ^ sha256_pkg::rotr(w_reg[14], 19)
             ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        t1 = v_reg[7] + (sha256_pkg::rotr(v_reg[4], 6) ^ sha256_pkg::rotr(v_reg[4], 11)
             ^ sha256_pkg::rotr(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + sha256_pkg::round_k(round_reg) + w_cur;
        t2 = (sha256_pkg::rotr(v_reg[0], 2) ^ sha256_pkg::rotr(v_reg[0], 13)
             ^ sha256_pkg::rotr(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Block bytes shift in at the low byte of w_reg[15], so after 64 bytes the window holds
    // the block in order. The length moves the window on by eight bytes.
    always_ff @(posedge aclk) begin
        if (cmd.round_init) begin
            round_reg <= '0;
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= h_reg[i];
            end
        end else if (cmd.round_step) begin
            round_reg <= round_reg + 1'b1;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
        end else if (cmd.buf_wr) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= {w_reg[i][23:0], w_reg[i + 1][31:24]};
            end
            w_reg[15] <= {w_reg[15][23:0], wr_byte};
        end else if (cmd.len_wr) begin
            for (int i = 0; i < 14; i++) begin
                w_reg[i] <= w_reg[i + 2];
            end
            w_reg[14] <= bits[63:32];
            w_reg[15] <= bits[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.hash_init) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= sha256_pkg::start_h(3'(i));
            end
        end else if (cmd.hash_update) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    assign status.round_idx = round_reg;
    assign hash_word = h_reg[cmd.out_sel];

endmodule

`default_nettype wire

@@ rtl/sha256_ctrl.sv @@
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_is_last,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [2:0]                   m_index,
    input  wire sha256_pkg::dp_status_t  status,
    output sha256_pkg::dp_cmd_t          cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PAD   = 7'b0000010,
        ST_ZERO  = 7'b0000100,
        ST_INIT  = 7'b0001000,
        ST_ROUND = 7'b0010000,
        ST_FOLD  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] fill_reg, fill_next;
    logic       fin_reg, fin_next;
    logic       len_reg, len_next;
    logic       pad_reg, pad_next;
    logic [2:0] idx_reg, idx_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_index = idx_reg;

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        fin_next   = fin_reg;
        len_next   = len_reg;
        pad_next   = pad_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.buf_src  = sha256_pkg::WSRC_ZERO;
        cmd.out_sel  = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.buf_src = sha256_pkg::WSRC_MSG;
                if (s_valid) begin
                    cmd.buf_wr    = 1'b1;
                    cmd.total_inc = 1'b1;
                    fill_next     = fill_reg + 1'b1;
                    fin_next      = s_is_last;
                    len_next      = 1'b0;
                    pad_next      = 1'b0;
                    if (fill_reg == 6'd63) begin
                        state_next = ST_INIT;
                    end else if (s_is_last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.buf_wr  = 1'b1;
                cmd.buf_src = sha256_pkg::WSRC_PAD;
                fill_next   = fill_reg + 1'b1;
                pad_next    = 1'b1;
                state_next  = (fill_reg == 6'd63) ? ST_INIT : ST_ZERO;
                if (fill_reg <= 6'd55) begin
                    len_next = 1'b1;
                end
            end
            ST_ZERO: begin
                if (len_reg && fill_reg == 6'd56) begin
                    cmd.len_wr = 1'b1;
                    fill_next  = 6'd0;
                    state_next = ST_INIT;
                end else begin
                    cmd.buf_wr = 1'b1;
                    fill_next  = fill_reg + 1'b1;
                    if (fill_reg == 6'd63) begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                cmd.round_init = 1'b1;
                state_next     = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_step = 1'b1;
                if (status.round_idx == 6'd63) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.hash_update = 1'b1;
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (len_reg) begin
                    idx_next   = 3'd0;
                    state_next = ST_OUT;
                end else if (pad_reg) begin
                    len_next   = 1'b1;
                    state_next = ST_ZERO;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 3'd7) begin
                        cmd.hash_init = 1'b1;
                        cmd.total_clr = 1'b1;
                        fin_next      = 1'b0;
                        fill_next     = 6'd0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            fin_reg   <= 1'b0;
            len_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            fin_reg   <= fin_next;
            len_reg   <= len_next;
            pad_reg   <= pad_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sha256_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the eight digest words of each message.
//
// The input channel (s_valid, s_ready, s_item) takes one message byte per
// item, with is_last set on the final byte. The output channel (m_valid,
// m_ready, m_item) returns eight items per message, H0 first, last_word set
// on the eighth.
// A byte that does not complete a block leaves the input ready for the next. The
// 64th byte of a block starts a compression: one load, 64 rounds through one
// shared round unit, one fold into the hash words. After the final byte the
// padding is written one byte per cycle up to the end of the block, and one
// or two compressions follow before the first digest word appears. No byte
// is accepted while a block is compressed or the padding is written.
// Reset loads the initial hash values and empties the buffer. When the
// receiver stalls, the current digest word holds and no input is accepted
// until all eight words are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire sha256_pkg::in_item_t   s_item,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output sha256_pkg::out_item_t       m_item
);

    sha256_pkg::dp_cmd_t    cmd;
    sha256_pkg::dp_status_t status;
    logic [2:0]             index;
    logic [31:0]            word;

    sha256_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_is_last (s_item.is_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_index   (index),
        .status    (status),
        .cmd       (cmd)
    );

    sha256_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .msg_byte  (s_item.data_byte),
        .status    (status),
        .hash_word (word)
    );

    assign m_item.digest_word = word;
    assign m_item.word_index  = index;
    assign m_item.last_word   = (index == 3'd7);

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Drives byte streams of varied lengths through the hasher with random
// gaps on both channels, computes each digest with its own SHA-256 model
// and compares every returned digest word with the expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    sha256_pkg::in_item_t  s_item = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    sha256_pkg::out_item_t m_item;

    sha256_pkg::in_item_t  byte_queue[$];
    sha256_pkg::out_item_t digest_queue[$];
    bit        failed = 1'b0;
    bit        calm = 1'b0;
    bit        hold_send = 1'b0;

    logic [31:0] hash_state[8];
    logic [7:0]  block_bytes[64];
    int unsigned fill_level;
    logic [60:0] msg_bytes;

    localparam logic [31:0] K_TABLE[64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] H_INIT[8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    sha256_stream_hasher i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #1 aclk = ~aclk;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            w[i] = w[i-16] + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
    endtask

    task automatic hash_byte(sha256_pkg::in_item_t it);
        logic [63:0]           bits;
        sha256_pkg::out_item_t o;
        block_bytes[fill_level] = it.data_byte;
        fill_level = (fill_level + 1) % 64;
        msg_bytes = msg_bytes + 1;
        if (fill_level == 0) compress_block();
        if (it.is_last) begin
            block_bytes[fill_level] = sha256_pkg::PAD_BYTE;
            for (int i = fill_level + 1; i < 64; i++) block_bytes[i] = 8'h00;
            if (fill_level > 55) begin
                compress_block();
                for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
            end
            bits = {msg_bytes, 3'b000};
            for (int i = 0; i < 8; i++) block_bytes[56+i] = bits[63-8*i -: 8];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                o.digest_word = hash_state[i];
                o.word_index  = 3'(i);
                o.last_word   = (i == 7);
                digest_queue.push_back(o);
            end
            for (int i = 0; i < 8; i++) hash_state[i] = H_INIT[i];
            fill_level = 0;
            msg_bytes = '0;
        end
    endtask

    task automatic queue_message(int len, int pattern);
        sha256_pkg::in_item_t it;
        for (int i = 0; i < len; i++) begin
            case (pattern)
                0: it.data_byte = 8'h00;
                1: it.data_byte = 8'hff;
                default: it.data_byte = 8'($urandom);
            endcase
            it.is_last = (i == len - 1);
            byte_queue.push_back(it);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) hash_byte(s_item);
            if (!(s_valid && !s_ready)) begin
                if (byte_queue.size() > 0 && !hold_send
                        && (calm || $urandom_range(99) >= 9)) begin
                    s_valid <= 1'b1;
                    s_item  <= byte_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (digest_queue.size() == 0) begin
                    $display("%0t: unexpected digest word %h", $realtime, m_item);
                    failed = 1'b1;
                end else begin
                    sha256_pkg::out_item_t exp_item;
                    exp_item = digest_queue.pop_front();
                    if (m_item !== exp_item) begin
                        $display("%0t: expected %h/%0d/%0d actual %h/%0d/%0d", $realtime,
                                 exp_item.digest_word, exp_item.word_index,
                                 exp_item.last_word, m_item.digest_word,
                                 m_item.word_index, m_item.last_word);
                        failed = 1'b1;
                    end
                end
            end
            m_ready <= calm || ($urandom_range(99) >= 9);
        end
    end

    initial begin
        for (int i = 0; i < 8; i++) hash_state[i] = H_INIT[i];
        fill_level = 0;
        msg_bytes = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        queue_message(1, 0);
        queue_message(1, 1);
        queue_message(3, 2);
        while (byte_queue.size() > 0 || s_valid || digest_queue.size() > 0)
            @(posedge aclk);
        hold_send = 1'b1;
        repeat (300) @(posedge aclk);
        hold_send = 1'b0;
        queue_message(64, 2);
        while (byte_queue.size() > 0) @(posedge aclk);
        calm = 1'b1;
        queue_message(56, 2);
        while (byte_queue.size() > 0 || s_valid || digest_queue.size() > 0)
            @(posedge aclk);
        calm = 1'b0;
        while (digest_queue.size() > 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (!failed) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/sha256_pkg.sv
rtl/sha256_datapath.sv
rtl/sha256_ctrl.sv
rtl/sha256_stream_hasher.sv
sim/testbench.sv
